// File: rtl/core/krt_pkg.sv
package krt_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int RESULT_CAP  = 16;

    localparam int ADDR_W   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W    = $clog2(TABLE_DEPTH + 1);
    localparam int OP_W     = 3;
    localparam int KEY_W    = 16;
    localparam int TEMP_W   = 16;
    localparam int STATUS_W = 3;

    // opcodes
    localparam logic [OP_W-1:0] OP_INSERT = 3'd0;
    localparam logic [OP_W-1:0] OP_DELETE = 3'd1;
    localparam logic [OP_W-1:0] OP_INCR   = 3'd2;
    localparam logic [OP_W-1:0] OP_QUERY  = 3'd3;
    localparam logic [OP_W-1:0] OP_DUMP   = 3'd4;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_DUPLICATE = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd3;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd4;

    typedef enum logic [1:0] {
        KSEL_IN,
        KSEL_RD,
        KSEL_ZERO
    } ksel_t;

    typedef enum logic [1:0] {
        TSEL_ZERO,
        TSEL_RD,
        TSEL_INC
    } tsel_t;

    typedef enum logic [1:0] {
        WSEL_APPEND,
        WSEL_SHIFT,
        WSEL_INC
    } wsel_t;

    typedef struct packed {
        logic                load;
        logic                rd_issue;
        logic                scan_dump;
        logic                seek;
        logic                wr_key_en;
        logic                wr_cnt_en;
        wsel_t               wsel;
        logic                cnt_inc;
        logic                cnt_dec;
        logic                out_load;
        logic [STATUS_W-1:0] out_status;
        ksel_t               out_ksel;
        tsel_t               out_tsel;
        logic                out_last;
    } cmd_t;

    typedef struct packed {
        logic [OP_W-1:0]  op;
        logic             hit;
        logic             pend;
        logic             scan_done;
        logic             full;
        logic             empty;
        logic             more_dump;
        logic             out_free;
        logic [CNT_W-1:0] count;
    } sts_t;

endpackage

// File: rtl/core/krt_ctrl.sv
module krt_ctrl (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [krt_pkg::OP_W-1:0]     opcode,
    input  krt_pkg::sts_t                sts,
    output krt_pkg::cmd_t                cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_SHIFT,
        S_RESP,
        S_DUMP_RD,
        S_DUMP_OUT
    } state_t;

    state_t                        state_reg, state_next;
    logic [krt_pkg::STATUS_W-1:0]  resp_status_reg, resp_status_next;
    krt_pkg::ksel_t                resp_ksel_reg, resp_ksel_next;
    krt_pkg::tsel_t                resp_tsel_reg, resp_tsel_next;

    always_comb
    begin
        cmd              = '0;
        state_next       = state_reg;
        resp_status_next = resp_status_reg;
        resp_ksel_next   = resp_ksel_reg;
        resp_tsel_next   = resp_tsel_reg;
        in_ready         = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    unique case (opcode) inside
                        krt_pkg::OP_INSERT, krt_pkg::OP_DELETE,
                        krt_pkg::OP_INCR, krt_pkg::OP_QUERY:
                            state_next = S_SEARCH;
                        krt_pkg::OP_DUMP:
                            state_next = S_DUMP_RD;
                        default:
                            state_next = S_IDLE;
                    endcase
                end
            end

            S_SEARCH:
            begin
                resp_ksel_next = krt_pkg::KSEL_IN;
                if (sts.hit)
                begin
                    state_next = S_RESP;
                    unique case (sts.op)
                        krt_pkg::OP_INSERT:
                        begin
                            resp_status_next = krt_pkg::ST_DUPLICATE;
                            resp_tsel_next   = krt_pkg::TSEL_ZERO;
                        end
                        krt_pkg::OP_DELETE:
                        begin
                            cmd.seek   = 1'b1;
                            state_next = S_SHIFT;
                        end
                        krt_pkg::OP_INCR:
                        begin
                            cmd.wr_cnt_en    = 1'b1;
                            cmd.wsel         = krt_pkg::WSEL_INC;
                            resp_status_next = krt_pkg::ST_OK;
                            resp_tsel_next   = krt_pkg::TSEL_INC;
                        end
                        default:
                        begin
                            resp_status_next = krt_pkg::ST_OK;
                            resp_tsel_next   = krt_pkg::TSEL_RD;
                        end
                    endcase
                end
                else if (sts.scan_done)
                begin
                    state_next     = S_RESP;
                    resp_tsel_next = krt_pkg::TSEL_ZERO;
                    if (sts.op == krt_pkg::OP_INSERT)
                    begin
                        if (sts.full)
                        begin
                            resp_status_next = krt_pkg::ST_FULL;
                        end
                        else
                        begin
                            cmd.wr_key_en    = 1'b1;
                            cmd.wr_cnt_en    = 1'b1;
                            cmd.wsel         = krt_pkg::WSEL_APPEND;
                            cmd.cnt_inc      = 1'b1;
                            resp_status_next = krt_pkg::ST_OK;
                        end
                    end
                    else
                    begin
                        resp_status_next = krt_pkg::ST_NOT_FOUND;
                    end
                end
                else
                begin
                    cmd.rd_issue = 1'b1;
                end
            end

            S_SHIFT:
            begin
                if (sts.scan_done)
                begin
                    cmd.cnt_dec      = 1'b1;
                    resp_status_next = krt_pkg::ST_OK;
                    resp_ksel_next   = krt_pkg::KSEL_IN;
                    resp_tsel_next   = krt_pkg::TSEL_ZERO;
                    state_next       = S_RESP;
                end
                else
                begin
                    // read entry i+1 while writing the previous read back one slot down
                    cmd.rd_issue = 1'b1;
                    if (sts.pend)
                    begin
                        cmd.wr_key_en = 1'b1;
                        cmd.wr_cnt_en = 1'b1;
                        cmd.wsel      = krt_pkg::WSEL_SHIFT;
                    end
                end
            end

            S_RESP:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load   = 1'b1;
                    cmd.out_status = resp_status_reg;
                    cmd.out_ksel   = resp_ksel_reg;
                    cmd.out_tsel   = resp_tsel_reg;
                    cmd.out_last   = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            S_DUMP_RD:
            begin
                if (sts.empty)
                begin
                    resp_status_next = krt_pkg::ST_EMPTY;
                    resp_ksel_next   = krt_pkg::KSEL_ZERO;
                    resp_tsel_next   = krt_pkg::TSEL_ZERO;
                    state_next       = S_RESP;
                end
                else
                begin
                    cmd.rd_issue  = 1'b1;
                    cmd.scan_dump = 1'b1;
                    state_next    = S_DUMP_OUT;
                end
            end

            S_DUMP_OUT:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load   = 1'b1;
                    cmd.out_status = krt_pkg::ST_OK;
                    cmd.out_ksel   = krt_pkg::KSEL_RD;
                    cmd.out_tsel   = krt_pkg::TSEL_RD;
                    cmd.out_last   = !sts.more_dump;
                    if (sts.more_dump)
                    begin
                        cmd.rd_issue  = 1'b1;
                        cmd.scan_dump = 1'b1;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            resp_status_reg <= krt_pkg::ST_OK;
            resp_ksel_reg   <= krt_pkg::KSEL_IN;
            resp_tsel_reg   <= krt_pkg::TSEL_ZERO;
        end
        else
        begin
            state_reg       <= state_next;
            resp_status_reg <= resp_status_next;
            resp_ksel_reg   <= resp_ksel_next;
            resp_tsel_reg   <= resp_tsel_next;
        end
    end

endmodule

// File: rtl/core/krt_dpath.sv
module krt_dpath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  krt_pkg::cmd_t                 cmd,
    output krt_pkg::sts_t                 sts,
    input  logic [krt_pkg::OP_W-1:0]      opcode,
    input  logic [krt_pkg::KEY_W-1:0]     key,
    input  logic                          out_ready,
    output logic                          out_valid,
    output logic [krt_pkg::STATUS_W-1:0]  status,
    output logic [krt_pkg::KEY_W-1:0]     record_key,
    output logic [krt_pkg::TEMP_W-1:0]    temperature,
    output logic                          last
);

    logic [krt_pkg::KEY_W-1:0]    key_mem [krt_pkg::TABLE_DEPTH];
    logic [krt_pkg::TEMP_W-1:0]   cnt_mem [krt_pkg::TABLE_DEPTH];

    logic [krt_pkg::OP_W-1:0]     op_reg;
    logic [krt_pkg::KEY_W-1:0]    key_reg;
    logic [krt_pkg::CNT_W-1:0]    count_reg, count_next;
    logic [krt_pkg::CNT_W-1:0]    idx_reg, idx_next;
    logic                         pend_reg;
    logic [krt_pkg::ADDR_W-1:0]   rd_idx_reg;
    logic [krt_pkg::KEY_W-1:0]    rd_key_reg;
    logic [krt_pkg::TEMP_W-1:0]   rd_cnt_reg;

    logic                         out_valid_reg;
    logic [krt_pkg::STATUS_W-1:0] out_status_reg;
    logic [krt_pkg::KEY_W-1:0]    out_key_reg;
    logic [krt_pkg::TEMP_W-1:0]   out_temp_reg;
    logic                         out_last_reg;

    logic [krt_pkg::CNT_W-1:0]    dump_lim;
    logic [krt_pkg::CNT_W-1:0]    scan_lim;
    logic                         issue;
    logic [krt_pkg::ADDR_W-1:0]   rd_addr;
    logic [krt_pkg::ADDR_W-1:0]   wr_addr;
    logic [krt_pkg::KEY_W-1:0]    wr_key;
    logic [krt_pkg::TEMP_W-1:0]   wr_cnt;
    logic [krt_pkg::TEMP_W-1:0]   inc_val;
    logic [krt_pkg::KEY_W-1:0]    sel_key;
    logic [krt_pkg::TEMP_W-1:0]   sel_temp;
    logic                         out_free;

    assign dump_lim = (int'(count_reg) > krt_pkg::RESULT_CAP) ?
                      krt_pkg::CNT_W'(krt_pkg::RESULT_CAP) : count_reg;
    assign scan_lim = cmd.scan_dump ? dump_lim : count_reg;
    assign issue    = cmd.rd_issue && (idx_reg < scan_lim);
    assign rd_addr  = idx_reg[krt_pkg::ADDR_W-1:0];

    // saturating increment
    assign inc_val = (rd_cnt_reg == '1) ? rd_cnt_reg : rd_cnt_reg + 1'b1;

    always_comb
    begin
        case (cmd.wsel)
            krt_pkg::WSEL_APPEND:
            begin
                wr_addr = count_reg[krt_pkg::ADDR_W-1:0];
                wr_key  = key_reg;
                wr_cnt  = '0;
            end
            krt_pkg::WSEL_SHIFT:
            begin
                wr_addr = rd_idx_reg - 1'b1;
                wr_key  = rd_key_reg;
                wr_cnt  = rd_cnt_reg;
            end
            default:
            begin
                wr_addr = rd_idx_reg;
                wr_key  = rd_key_reg;
                wr_cnt  = inc_val;
            end
        endcase
    end

    always_comb
    begin
        idx_next = idx_reg;
        if (cmd.load)
        begin
            idx_next = '0;
        end
        else if (cmd.seek)
        begin
            idx_next = krt_pkg::CNT_W'(rd_idx_reg) + 1'b1;
        end
        else if (issue)
        begin
            idx_next = idx_reg + 1'b1;
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (cmd.cnt_inc)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (cmd.cnt_dec)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_comb
    begin
        case (cmd.out_ksel)
            krt_pkg::KSEL_IN: sel_key = key_reg;
            krt_pkg::KSEL_RD: sel_key = rd_key_reg;
            default:          sel_key = '0;
        endcase
        case (cmd.out_tsel)
            krt_pkg::TSEL_RD:  sel_temp = rd_cnt_reg;
            krt_pkg::TSEL_INC: sel_temp = inc_val;
            default:           sel_temp = '0;
        endcase
    end

    assign out_free = !out_valid_reg || out_ready;

    // table memories, registered read
    always_ff @(posedge clk)
    begin
        if (cmd.wr_key_en)
        begin
            key_mem[wr_addr] <= wr_key;
        end
        if (cmd.wr_cnt_en)
        begin
            cnt_mem[wr_addr] <= wr_cnt;
        end
        if (issue)
        begin
            rd_key_reg <= key_mem[rd_addr];
            rd_cnt_reg <= cnt_mem[rd_addr];
            rd_idx_reg <= rd_addr;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg  <= opcode;
            key_reg <= key;
        end
        if (cmd.out_load)
        begin
            out_status_reg <= cmd.out_status;
            out_key_reg    <= sel_key;
            out_temp_reg   <= sel_temp;
            out_last_reg   <= cmd.out_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            idx_reg       <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            idx_reg   <= idx_next;
            pend_reg  <= issue;
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_comb
    begin
        sts.op        = op_reg;
        sts.hit       = pend_reg && (rd_key_reg == key_reg);
        sts.pend      = pend_reg;
        sts.scan_done = !pend_reg && !(idx_reg < count_reg);
        sts.full      = count_reg >= krt_pkg::CNT_W'(krt_pkg::TABLE_DEPTH);
        sts.empty     = count_reg == '0;
        sts.more_dump = idx_reg < dump_lim;
        sts.out_free  = out_free;
        sts.count     = count_reg;
    end

    assign out_valid   = out_valid_reg;
    assign status      = out_status_reg;
    assign record_key  = out_key_reg;
    assign temperature = out_temp_reg;
    assign last        = out_last_reg;

endmodule

// File: rtl/core/keyed_record_table_core.sv
// Ordered table of up to 16 records (unique 16-bit key, saturating 16-bit
// temperature counter) driven by insert / delete / increment / query / dump
// operations. One operation is worked on at a time; in_ready is high only
// while the block is idle, but an idle block takes a new operation even
// while the previous result still waits in the output register. The table
// sits in single-port-read memories with a registered read, so a key search
// walks the valid records one per cycle (stopping early on a hit), a delete
// then moves every record behind the removed one down one slot to close the
// gap, and a dump streams one record per cycle while out_ready stays high
// (at most 16 results, the final one with last set). Opcodes 5 to 7 are
// consumed with no result.
module keyed_record_table_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [krt_pkg::OP_W-1:0]      opcode,
    input  logic [krt_pkg::KEY_W-1:0]     key,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [krt_pkg::STATUS_W-1:0]  status,
    output logic [krt_pkg::KEY_W-1:0]     record_key,
    output logic [krt_pkg::TEMP_W-1:0]    temperature,
    output logic                          last
);

    krt_pkg::cmd_t cmd;
    krt_pkg::sts_t sts;

    krt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .opcode   (opcode),
        .sts      (sts),
        .cmd      (cmd)
    );

    krt_dpath u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .opcode      (opcode),
        .key         (key),
        .out_ready   (out_ready),
        .out_valid   (out_valid),
        .status      (status),
        .record_key  (record_key),
        .temperature (temperature),
        .last        (last)
    );

    // record count never exceeds the table depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        sts.count <= krt_pkg::CNT_W'(krt_pkg::TABLE_DEPTH))
        else $error("record count above table depth");

    // the table is never written while the block waits for a new transfer
    a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !(cmd.wr_key_en || cmd.wr_cnt_en))
        else $error("table write while idle");

    // one operation moves the count by at most one
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (sts.count != $past(sts.count)) |->
        (sts.count == $past(sts.count) + 1'b1 || sts.count == $past(sts.count) - 1'b1))
        else $error("record count jumped");

    // a result is only loaded when the output register can take it
    a_out_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid || out_ready))
        else $error("result overwritten before transfer");

endmodule
